// ===== hw/rtl/jtm_pkg.sv =====
// Shared types, codes and the TAP next-state function for the JTAG shift master.
`timescale 1ns / 1ps

package jtm_pkg;

    localparam int MAX_SHIFT_BITS_DEF = 32;
    localparam int RESET_CYCLES       = 5;
    localparam int IN_TDATA_W         = 48;
    localparam int OUT_TDATA_W        = 16;

    localparam logic [1:0] CMD_RESET    = 2'd0;
    localparam logic [1:0] CMD_IDLE     = 2'd1;
    localparam logic [1:0] CMD_SHIFT_IR = 2'd2;
    localparam logic [1:0] CMD_SHIFT_DR = 2'd3;

    localparam logic [3:0] TS_TLR      = 4'd0;
    localparam logic [3:0] TS_RTI      = 4'd1;
    localparam logic [3:0] TS_SEL_DR   = 4'd2;
    localparam logic [3:0] TS_CAP_DR   = 4'd3;
    localparam logic [3:0] TS_SHIFT_DR = 4'd4;
    localparam logic [3:0] TS_EXIT1_DR = 4'd5;
    localparam logic [3:0] TS_PAUSE_DR = 4'd6;
    localparam logic [3:0] TS_EXIT2_DR = 4'd7;
    localparam logic [3:0] TS_UPD_DR   = 4'd8;
    localparam logic [3:0] TS_SEL_IR   = 4'd9;
    localparam logic [3:0] TS_CAP_IR   = 4'd10;
    localparam logic [3:0] TS_SHIFT_IR = 4'd11;
    localparam logic [3:0] TS_EXIT1_IR = 4'd12;
    localparam logic [3:0] TS_PAUSE_IR = 4'd13;
    localparam logic [3:0] TS_EXIT2_IR = 4'd14;
    localparam logic [3:0] TS_UPD_IR   = 4'd15;

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_RST,
        ST_RTI,
        ST_SEL_DR,
        ST_SEL_IR,
        ST_CAP,
        ST_ENTER,
        ST_SHIFT,
        ST_EXIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic tms;
        logic shift_bit;
        logic last;
        logic clr_cnt;
        logic inc_cnt;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [3:0] tap_state;
        logic [1:0] cmd;
        logic       rst_end;
        logic       bit_end;
        logic       out_free;
    } t_dp_stat;

    function automatic logic [3:0] tap_next(input logic [3:0] st, input logic tms);
        logic [3:0] nx;
        case (st)
            TS_TLR:      nx = tms ? TS_TLR      : TS_RTI;
            TS_RTI:      nx = tms ? TS_SEL_DR   : TS_RTI;
            TS_SEL_DR:   nx = tms ? TS_SEL_IR   : TS_CAP_DR;
            TS_CAP_DR:   nx = tms ? TS_EXIT1_DR : TS_SHIFT_DR;
            TS_SHIFT_DR: nx = tms ? TS_EXIT1_DR : TS_SHIFT_DR;
            TS_EXIT1_DR: nx = tms ? TS_UPD_DR   : TS_PAUSE_DR;
            TS_PAUSE_DR: nx = tms ? TS_EXIT2_DR : TS_PAUSE_DR;
            TS_EXIT2_DR: nx = tms ? TS_UPD_DR   : TS_SHIFT_DR;
            TS_UPD_DR:   nx = tms ? TS_SEL_DR   : TS_RTI;
            TS_SEL_IR:   nx = tms ? TS_TLR      : TS_CAP_IR;
            TS_CAP_IR:   nx = tms ? TS_EXIT1_IR : TS_SHIFT_IR;
            TS_SHIFT_IR: nx = tms ? TS_EXIT1_IR : TS_SHIFT_IR;
            TS_EXIT1_IR: nx = tms ? TS_UPD_IR   : TS_PAUSE_IR;
            TS_PAUSE_IR: nx = tms ? TS_EXIT2_IR : TS_PAUSE_IR;
            TS_EXIT2_IR: nx = tms ? TS_UPD_IR   : TS_SHIFT_IR;
            TS_UPD_IR:   nx = tms ? TS_SEL_DR   : TS_RTI;
            default:     nx = TS_TLR;
        endcase
        return nx;
    endfunction

endpackage

// ===== hw/rtl/jtm_ctrl.sv =====
// Sequencer for the JTAG shift master: steps the TAP through the moves of one command.
`timescale 1ns / 1ps

module jtm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_cmd,
    output logic              o_in_ready,
    input  jtm_pkg::t_dp_stat i_stat,
    output jtm_pkg::t_dp_cmd  o_cmd
);

    jtm_pkg::t_state r_state;
    jtm_pkg::t_state n_state;

    logic go;
    logic in_shift_entry;

    assign go = i_stat.out_free;
    assign in_shift_entry = (i_stat.tap_state == jtm_pkg::TS_RTI) ||
                            (i_stat.tap_state == jtm_pkg::TS_UPD_DR) ||
                            (i_stat.tap_state == jtm_pkg::TS_UPD_IR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jtm_pkg::ST_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            jtm_pkg::ST_WAIT: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        jtm_pkg::CMD_RESET: n_state = jtm_pkg::ST_RST;
                        jtm_pkg::CMD_IDLE: begin
                            if (i_stat.tap_state == jtm_pkg::TS_TLR) begin
                                n_state = jtm_pkg::ST_RTI;
                            end
                        end
                        default: begin
                            n_state = in_shift_entry ? jtm_pkg::ST_SEL_DR : jtm_pkg::ST_RST;
                        end
                    endcase
                end
            end
            jtm_pkg::ST_RST: begin
                if (go && i_stat.rst_end) begin
                    n_state = (i_stat.cmd == jtm_pkg::CMD_RESET) ? jtm_pkg::ST_WAIT
                                                                 : jtm_pkg::ST_RTI;
                end
            end
            jtm_pkg::ST_RTI: begin
                if (go) begin
                    n_state = (i_stat.cmd == jtm_pkg::CMD_IDLE) ? jtm_pkg::ST_WAIT
                                                                : jtm_pkg::ST_SEL_DR;
                end
            end
            jtm_pkg::ST_SEL_DR: begin
                if (go) begin
                    n_state = (i_stat.cmd == jtm_pkg::CMD_SHIFT_IR) ? jtm_pkg::ST_SEL_IR
                                                                    : jtm_pkg::ST_CAP;
                end
            end
            jtm_pkg::ST_SEL_IR: if (go) n_state = jtm_pkg::ST_CAP;
            jtm_pkg::ST_CAP:    if (go) n_state = jtm_pkg::ST_ENTER;
            jtm_pkg::ST_ENTER:  if (go) n_state = jtm_pkg::ST_SHIFT;
            jtm_pkg::ST_SHIFT: begin
                if (go && i_stat.bit_end) begin
                    n_state = jtm_pkg::ST_EXIT;
                end
            end
            jtm_pkg::ST_EXIT:   if (go) n_state = jtm_pkg::ST_WAIT;
            default:            n_state = jtm_pkg::ST_WAIT;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            jtm_pkg::ST_WAIT: begin
                o_in_ready    = 1'b1;
                o_cmd.load    = i_in_valid;
                o_cmd.clr_cnt = i_in_valid;
            end
            jtm_pkg::ST_RST: begin
                o_cmd.emit    = go;
                o_cmd.tms     = 1'b1;
                o_cmd.inc_cnt = go;
                o_cmd.last    = i_stat.rst_end && (i_stat.cmd == jtm_pkg::CMD_RESET);
            end
            jtm_pkg::ST_RTI: begin
                o_cmd.emit = go;
                o_cmd.last = (i_stat.cmd == jtm_pkg::CMD_IDLE);
            end
            jtm_pkg::ST_SEL_DR, jtm_pkg::ST_SEL_IR: begin
                o_cmd.emit = go;
                o_cmd.tms  = 1'b1;
            end
            jtm_pkg::ST_CAP: begin
                o_cmd.emit = go;
            end
            jtm_pkg::ST_ENTER: begin
                // counter restarts as the bit index of the shift
                o_cmd.emit    = go;
                o_cmd.clr_cnt = go;
            end
            jtm_pkg::ST_SHIFT: begin
                o_cmd.emit      = go;
                o_cmd.tms       = i_stat.bit_end;
                o_cmd.shift_bit = 1'b1;
                o_cmd.inc_cnt   = go;
            end
            jtm_pkg::ST_EXIT: begin
                o_cmd.emit = go;
                o_cmd.tms  = 1'b1;
                o_cmd.last = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/jtm_dp.sv =====
// Datapath for the JTAG shift master: command latch, counters, TAP tracker, output word.
`timescale 1ns / 1ps

module jtm_dp #(
    parameter int MAX_SHIFT_BITS = jtm_pkg::MAX_SHIFT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jtm_pkg::t_dp_cmd  i_cmd,
    output jtm_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_in_cmd,
    input  logic [5:0]        i_bit_count,
    input  logic [31:0]       i_tdi_word,
    input  logic              i_capture_enable,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_tms_level,
    output logic              o_tdi_level,
    output logic              o_sample_tdo,
    output logic [4:0]        o_bit_index,
    output logic [3:0]        o_tap_state_now,
    output logic              o_last
);

    localparam int CW    = $clog2(MAX_SHIFT_BITS + 1);
    localparam int CNT_W = (CW > 3) ? CW : 3;

    logic [1:0]       r_cmd;
    logic [31:0]      r_shreg;
    logic             r_cap;
    logic [CNT_W-1:0] r_cnt_last;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_tap;
    logic             r_ovalid;
    logic             r_tms;
    logic             r_tdi;
    logic             r_sample;
    logic [4:0]       r_idx;
    logic             r_last;

    logic [5:0] count_sat;
    logic       sample;

    always_comb begin
        if (i_bit_count == 6'd0) begin
            count_sat = 6'd1;
        end else if (i_bit_count > 6'(MAX_SHIFT_BITS)) begin
            count_sat = 6'(MAX_SHIFT_BITS);
        end else begin
            count_sat = i_bit_count;
        end
    end

    assign sample = i_cmd.shift_bit && r_cap;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_in_cmd;
            r_cap      <= i_capture_enable;
            r_cnt_last <= CNT_W'(count_sat - 6'd1);
        end
        // drain shifted bits; zeros follow past the word
        if (i_cmd.load) begin
            r_shreg <= i_tdi_word;
        end else if (i_cmd.emit && i_cmd.shift_bit) begin
            r_shreg <= {1'b0, r_shreg[31:1]};
        end
        if (i_cmd.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_cmd.inc_cnt) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.emit) begin
            r_tms    <= i_cmd.tms;
            r_tdi    <= i_cmd.shift_bit && r_shreg[0];
            r_sample <= sample;
            r_idx    <= sample ? 5'(r_cnt) : 5'd0;
            r_last   <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap    <= jtm_pkg::TS_TLR;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_tap <= jtm_pkg::tap_next(r_tap, i_cmd.tms);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.tap_state = r_tap;
    assign o_stat.cmd       = r_cmd;
    assign o_stat.rst_end   = (r_cnt == CNT_W'(jtm_pkg::RESET_CYCLES - 1));
    assign o_stat.bit_end   = (r_cnt == r_cnt_last);
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid     = r_ovalid;
    assign o_tms_level     = r_tms;
    assign o_tdi_level     = r_tdi;
    assign o_sample_tdo    = r_sample;
    assign o_bit_index     = r_idx;
    assign o_tap_state_now = r_tap;
    assign o_last          = r_last;

endmodule

// ===== hw/rtl/jtag_tap_shift_master_top.sv =====
// Top level of the JTAG TAP shift master: stream ports, sequencer and datapath.
`timescale 1ns / 1ps

// Takes one command word (TAP reset, go to idle, shift IR, shift DR) and emits
// one output word per TCK cycle, carrying TMS, TDI, the TDO-sample strobe with
// its bit index and the tracked TAP state; tlast marks the final cycle of a
// command. Commands run one at a time: a command is taken only while no cycles
// remain to be issued, and each cycle takes one clock when the output side is
// ready. Reset walks the TAP to Test-Logic-Reset with TMS high; go to idle
// leaves Test-Logic-Reset for Run-Test/Idle and does nothing elsewhere; a shift
// walks Select-DR (and Select-IR), Capture, Shift, Exit1 and Update, first
// resetting the TAP and moving it to Run-Test/Idle when it is in neither
// Run-Test/Idle nor an Update state.
// Bit counts of zero shift one bit; counts above MAX_SHIFT_BITS saturate.
module jtag_tap_shift_master_top #(
    parameter int MAX_SHIFT_BITS = jtm_pkg::MAX_SHIFT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // cmd[1:0], bit_count[7:2], tdi_word[39:8], capture_enable[40], zero[47:41]
    input  logic [jtm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tms_level[0], tdi_level[1], sample_tdo[2], bit_index[7:3],
    // tap_state_now[11:8], zero[15:12]
    output logic [jtm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    jtm_pkg::t_dp_cmd  dp_cmd;
    jtm_pkg::t_dp_stat dp_stat;

    logic       tms_level;
    logic       tdi_level;
    logic       sample_tdo;
    logic [4:0] bit_index;
    logic [3:0] tap_state_now;

    jtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (i_s_axis_tdata[1:0]),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    jtm_dp #(
        .MAX_SHIFT_BITS (MAX_SHIFT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_in_cmd         (i_s_axis_tdata[1:0]),
        .i_bit_count      (i_s_axis_tdata[7:2]),
        .i_tdi_word       (i_s_axis_tdata[39:8]),
        .i_capture_enable (i_s_axis_tdata[40]),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_tms_level      (tms_level),
        .o_tdi_level      (tdi_level),
        .o_sample_tdo     (sample_tdo),
        .o_bit_index      (bit_index),
        .o_tap_state_now  (tap_state_now),
        .o_last           (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'd0, tap_state_now, bit_index, sample_tdo, tdi_level, tms_level};

endmodule

// ===== tb/tck_cycle_checker.sv =====
// Predicts the TCK cycle words for each accepted command and compares them with the output stream.
`timescale 1ns / 1ps

module tck_cycle_checker #(
    parameter int MAX_SHIFT_BITS = jtm_pkg::MAX_SHIFT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_ready,
    input  logic [jtm_pkg::IN_TDATA_W-1:0]  i_cmd_data,
    input  logic                            i_tck_valid,
    input  logic                            i_tck_ready,
    input  logic [jtm_pkg::OUT_TDATA_W-1:0] i_tck_data,
    input  logic                            i_tck_last,
    output int                              o_pending,
    output int                              o_fail_count,
    output int                              o_words_checked
);

    typedef struct packed {
        logic       tms;
        logic       tdi;
        logic       sample;
        logic [4:0] bit_index;
        logic [3:0] tap_state;
        logic       last;
    } t_tck_cycle;

    t_tck_cycle tck_expect_q[$];
    logic [3:0] tap_model;
    int         err_cnt;
    int         word_cnt;

    initial begin
        o_pending       = 0;
        o_fail_count    = 0;
        o_words_checked = 0;
        tap_model       = jtm_pkg::TS_TLR;
        err_cnt         = 0;
        word_cnt        = 0;
    end

    // Pair of successors per TAP state: {on TMS high, on TMS low}.
    function automatic logic [3:0] tap_after(input logic [3:0] st, input logic tms);
        logic [7:0] succ;
        case (st)
            jtm_pkg::TS_TLR:      succ = {jtm_pkg::TS_TLR,      jtm_pkg::TS_RTI};
            jtm_pkg::TS_RTI:      succ = {jtm_pkg::TS_SEL_DR,   jtm_pkg::TS_RTI};
            jtm_pkg::TS_SEL_DR:   succ = {jtm_pkg::TS_SEL_IR,   jtm_pkg::TS_CAP_DR};
            jtm_pkg::TS_CAP_DR:   succ = {jtm_pkg::TS_EXIT1_DR, jtm_pkg::TS_SHIFT_DR};
            jtm_pkg::TS_SHIFT_DR: succ = {jtm_pkg::TS_EXIT1_DR, jtm_pkg::TS_SHIFT_DR};
            jtm_pkg::TS_EXIT1_DR: succ = {jtm_pkg::TS_UPD_DR,   jtm_pkg::TS_PAUSE_DR};
            jtm_pkg::TS_PAUSE_DR: succ = {jtm_pkg::TS_EXIT2_DR, jtm_pkg::TS_PAUSE_DR};
            jtm_pkg::TS_EXIT2_DR: succ = {jtm_pkg::TS_UPD_DR,   jtm_pkg::TS_SHIFT_DR};
            jtm_pkg::TS_UPD_DR:   succ = {jtm_pkg::TS_SEL_DR,   jtm_pkg::TS_RTI};
            jtm_pkg::TS_SEL_IR:   succ = {jtm_pkg::TS_TLR,      jtm_pkg::TS_CAP_IR};
            jtm_pkg::TS_CAP_IR:   succ = {jtm_pkg::TS_EXIT1_IR, jtm_pkg::TS_SHIFT_IR};
            jtm_pkg::TS_SHIFT_IR: succ = {jtm_pkg::TS_EXIT1_IR, jtm_pkg::TS_SHIFT_IR};
            jtm_pkg::TS_EXIT1_IR: succ = {jtm_pkg::TS_UPD_IR,   jtm_pkg::TS_PAUSE_IR};
            jtm_pkg::TS_PAUSE_IR: succ = {jtm_pkg::TS_EXIT2_IR, jtm_pkg::TS_PAUSE_IR};
            jtm_pkg::TS_EXIT2_IR: succ = {jtm_pkg::TS_UPD_IR,   jtm_pkg::TS_SHIFT_IR};
            default:              succ = {jtm_pkg::TS_SEL_DR,   jtm_pkg::TS_RTI};
        endcase
        return tms ? succ[7:4] : succ[3:0];
    endfunction

    task automatic add_cycle(input logic tms, input logic tdi, input logic smp,
                             input logic [4:0] idx);
        t_tck_cycle c;
        tap_model   = tap_after(tap_model, tms);
        c.tms       = tms;
        c.tdi       = tdi;
        c.sample    = smp;
        c.bit_index = smp ? idx : 5'd0;
        c.tap_state = tap_model;
        c.last      = 1'b0;
        tck_expect_q.push_back(c);
    endtask

    task automatic walk_to_reset();
        repeat (jtm_pkg::RESET_CYCLES) add_cycle(1'b1, 1'b0, 1'b0, 5'd0);
        tap_model = jtm_pkg::TS_TLR;
    endtask

    task automatic predict_command(input logic [jtm_pkg::IN_TDATA_W-1:0] w);
        logic [1:0]  cmd;
        logic [5:0]  count;
        logic [31:0] tdi_bits;
        logic        cap;
        int          nbits;
        int          base;
        t_tck_cycle  c;
        cmd      = w[1:0];
        count    = w[7:2];
        tdi_bits = w[39:8];
        cap      = w[40];
        base     = tck_expect_q.size();
        case (cmd)
            jtm_pkg::CMD_RESET: walk_to_reset();
            jtm_pkg::CMD_IDLE: begin
                if (tap_model == jtm_pkg::TS_TLR) add_cycle(1'b0, 1'b0, 1'b0, 5'd0);
            end
            default: begin
                nbits = (count == 0) ? 1 : int'(count);
                if (nbits > MAX_SHIFT_BITS) nbits = MAX_SHIFT_BITS;
                // only Run-Test/Idle and the Update states lead straight into a scan
                if (tap_model != jtm_pkg::TS_RTI && tap_model != jtm_pkg::TS_UPD_DR &&
                    tap_model != jtm_pkg::TS_UPD_IR) begin
                    walk_to_reset();
                    add_cycle(1'b0, 1'b0, 1'b0, 5'd0);
                end
                add_cycle(1'b1, 1'b0, 1'b0, 5'd0);
                if (cmd == jtm_pkg::CMD_SHIFT_IR) add_cycle(1'b1, 1'b0, 1'b0, 5'd0);
                add_cycle(1'b0, 1'b0, 1'b0, 5'd0);
                add_cycle(1'b0, 1'b0, 1'b0, 5'd0);
                for (int i = 0; i < nbits; i++)
                    add_cycle(i == nbits - 1, (i < 32) ? tdi_bits[i] : 1'b0, cap, i[4:0]);
                add_cycle(1'b1, 1'b0, 1'b0, 5'd0);
            end
        endcase
        if (tck_expect_q.size() > base) begin
            c = tck_expect_q.pop_back();
            c.last = 1'b1;
            tck_expect_q.push_back(c);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tck_cycle want;
        if (!i_rst_n) begin
            tck_expect_q.delete();
            tap_model = jtm_pkg::TS_TLR;
        end else begin
            // retire the output word first so a stray word never matches a fresh command
            if (i_tck_valid && i_tck_ready) begin
                word_cnt++;
                if (tck_expect_q.size() == 0) begin
                    $error("unexpected output word %h (tlast %0d) with nothing pending",
                           i_tck_data, i_tck_last);
                    err_cnt++;
                end else begin
                    want = tck_expect_q.pop_front();
                    check_field("tms_level",     want.tms,       i_tck_data[0]);
                    check_field("tdi_level",     want.tdi,       i_tck_data[1]);
                    check_field("sample_tdo",    want.sample,    i_tck_data[2]);
                    check_field("bit_index",     want.bit_index, i_tck_data[7:3]);
                    check_field("tap_state_now", want.tap_state, i_tck_data[11:8]);
                    check_field("last",          want.last,      i_tck_last);
                end
            end
            if (i_cmd_valid && i_cmd_ready) predict_command(i_cmd_data);
        end
        o_pending       <= tck_expect_q.size();
        o_fail_count    <= err_cnt;
        o_words_checked <= word_cnt;
    end

endmodule

// ===== tb/tb_jtag_tap_shift_master_top.sv =====
// Testbench top for the JTAG TAP shift master: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_jtag_tap_shift_master_top;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [jtm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [jtm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                            o_m_axis_tlast;

    int pending;
    int fail_count;
    int words_checked;

    int src_idle_pct;
    int sink_stall_pct;
    int n_shift;
    int n_reset;
    int n_idle;
    bit tap_in_reset;

    jtag_tap_shift_master_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    tck_cycle_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (i_s_axis_tvalid),
        .i_cmd_ready     (o_s_axis_tready),
        .i_cmd_data      (i_s_axis_tdata),
        .i_tck_valid     (o_m_axis_tvalid),
        .i_tck_ready     (i_m_axis_tready),
        .i_tck_data      (o_m_axis_tdata),
        .i_tck_last      (o_m_axis_tlast),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_words_checked (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("jtag_tap_shift_master_top test failed");
        $finish;
    end

    // receiver side: random backpressure, redrawn every cycle
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Enter and leave at a falling edge; the word is held until accepted.
    task automatic send_cmd(input logic [1:0] cmd, input logic [5:0] count,
                            input logic [31:0] tdi_bits, input logic cap);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, cap, tdi_bits, count, cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        case (cmd)
            jtm_pkg::CMD_RESET: n_reset++;
            jtm_pkg::CMD_IDLE:  n_idle++;
            default:            n_shift++;
        endcase
    endtask

    // hold off the sender until every predicted word has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 6)  return 6'd0;
        if (r < 14) return 6'($urandom_range(63, 33));
        if (r < 24) return 6'd32;
        return 6'($urandom_range(31, 1));
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    initial begin
        logic [1:0] cmd;
        int         r;
        int         counted;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        n_shift         = 0;
        n_reset         = 0;
        n_idle          = 0;
        tap_in_reset    = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle from reset and from idle, direct scans from the update
        // states, scans that first reset the TAP, zero and oversized counts
        send_cmd(jtm_pkg::CMD_IDLE,     6'd0,  32'h0000_0000, 1'b0);
        send_cmd(jtm_pkg::CMD_IDLE,     6'd0,  32'h0000_0000, 1'b0);
        send_cmd(jtm_pkg::CMD_SHIFT_DR, 6'd1,  32'hFFFF_FFFF, 1'b1);
        send_cmd(jtm_pkg::CMD_SHIFT_IR, 6'd32, 32'hFFFF_FFFF, 1'b1);
        send_cmd(jtm_pkg::CMD_SHIFT_DR, 6'd0,  32'h0000_0001, 1'b0);
        send_cmd(jtm_pkg::CMD_IDLE,     6'd63, 32'hFFFF_FFFF, 1'b1);
        send_cmd(jtm_pkg::CMD_RESET,    6'd0,  32'h0000_0000, 1'b0);
        send_cmd(jtm_pkg::CMD_SHIFT_IR, 6'd63, 32'hA5A5_A5A5, 1'b1);
        send_cmd(jtm_pkg::CMD_SHIFT_DR, 6'd33, 32'h5A5A_5A5A, 1'b1);
        send_cmd(jtm_pkg::CMD_RESET,    6'd0,  32'h0000_0000, 1'b0);
        send_cmd(jtm_pkg::CMD_RESET,    6'd63, 32'hFFFF_FFFF, 1'b1);
        send_cmd(jtm_pkg::CMD_IDLE,     6'd0,  32'h0000_0000, 1'b0);
        send_cmd(jtm_pkg::CMD_SHIFT_DR, 6'd32, 32'h0000_0000, 1'b0);
        send_cmd(jtm_pkg::CMD_SHIFT_DR, 6'd17, 32'h8000_0001, 1'b1);
        send_cmd(jtm_pkg::CMD_RESET,    6'd0,  32'h0000_0000, 1'b0);
        send_cmd(jtm_pkg::CMD_SHIFT_DR, 6'd1,  32'h0000_0000, 1'b0);
        send_cmd(jtm_pkg::CMD_SHIFT_IR, 6'd31, 32'h7FFF_FFFE, 1'b1);
        send_cmd(jtm_pkg::CMD_SHIFT_IR, 6'd2,  32'h0000_0002, 1'b0);
        tap_in_reset = 1'b0;
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            counted = 0;
            while (counted < 96) begin
                r = $urandom_range(99);
                if (r < 12)      cmd = jtm_pkg::CMD_RESET;
                else if (r < 22) cmd = jtm_pkg::CMD_IDLE;
                else if (r < 61) cmd = jtm_pkg::CMD_SHIFT_IR;
                else             cmd = jtm_pkg::CMD_SHIFT_DR;
                // an idle request outside Test-Logic-Reset is dropped by the block
                if (cmd != jtm_pkg::CMD_IDLE || tap_in_reset) counted++;
                tap_in_reset = (cmd == jtm_pkg::CMD_RESET);
                send_cmd(cmd, pick_count(), pick_word(), 1'($urandom_range(1)));
            end
            drain();
        end

        repeat (50) @(negedge i_clk);
        $display("Covered %0d scans, %0d TAP resets and %0d idle requests over four pacing mixes,",
                 n_shift, n_reset, n_idle);
        $display("comparing %0d TCK words field by field.", words_checked);
        if (fail_count == 0) begin
            $display("jtag_tap_shift_master_top test passed");
        end else begin
            $display("jtag_tap_shift_master_top test failed");
        end
        $finish;
    end

endmodule
